// ----- rtl/wlevd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wlevd_pkg
// Shared types and constants of the windowed light event detector.
// ----------------------------------------------------------------------------
package wlevd_pkg;

   localparam int WINDOW_SIZE_DEF = 32;
   localparam int MAX_EVENTS_DEF  = 16;

   localparam int LEVEL_W  = 22;
   localparam int ID_W     = 16;
   localparam int REQ_CNT_W = 16;
   localparam int COUNT_W  = 7;   // holds any window size up to 64
   localparam int MASK_W   = 16;
   localparam int HELD_W   = 6;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   localparam logic [LEVEL_W-1:0] MAX_LEVEL = 22'd3276800;

   localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_EVENT = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [LEVEL_W-1:0] level;
      logic [COUNT_W-1:0] count;
   } slot_entry_type;

   typedef struct packed {
      logic clear;   // zero all hit counters
      logic load;    // load one lane from a table read
      logic count;   // compare one ring reading against all lanes
   } lane_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/wlevd_ring.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wlevd_ring
// Reading ring: saturates and stores readings, tracks write pointer and fill.
// ----------------------------------------------------------------------------
module wlevd_ring #(
   parameter int WINDOW_SIZE = wlevd_pkg::WINDOW_SIZE_DEF,
   localparam int PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1,
   localparam int CNT_W = $clog2(WINDOW_SIZE + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [wlevd_pkg::LEVEL_W-1:0]  push_value,
   input  wire logic                           rd_en,
   input  wire logic [PTR_W-1:0]               rd_addr,
   output logic      [wlevd_pkg::LEVEL_W-1:0]  rd_data,
   output logic      [CNT_W-1:0]               held
);

   logic [wlevd_pkg::LEVEL_W-1:0] mem [WINDOW_SIZE];
   logic [wlevd_pkg::LEVEL_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]              wp_ff;
   logic [PTR_W-1:0]              wp_in;
   logic [CNT_W-1:0]              held_ff;
   logic [CNT_W-1:0]              held_in;
   logic [wlevd_pkg::LEVEL_W-1:0] sat_value;

   always_comb begin
      sat_value = (push_value > wlevd_pkg::MAX_LEVEL) ? wlevd_pkg::MAX_LEVEL : push_value;
      wp_in     = wp_ff;
      held_in   = held_ff;
      if (push) begin
         wp_in = (wp_ff == PTR_W'(WINDOW_SIZE - 1)) ? '0 : wp_ff + PTR_W'(1);
         if (held_ff != CNT_W'(WINDOW_SIZE)) begin
            held_in = held_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         held_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wp_ff] <= sat_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign held    = held_ff;

`ifndef SYNTHESIS
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(WINDOW_SIZE))
      else $error("ring fill above window size");

   a_ptr_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      held_ff != CNT_W'(WINDOW_SIZE) |-> wp_ff == PTR_W'(held_ff))
      else $error("write pointer out of step with fill before wrap");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      push && held_ff != CNT_W'(WINDOW_SIZE) |=> held_ff == CNT_W'($past(held_ff) + 1'b1))
      else $error("fill did not grow on push");
`endif

endmodule
`default_nettype wire

// ----- rtl/wlevd_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wlevd_table
// Event table: entry memory, valid bits and lowest free slot search.
// ----------------------------------------------------------------------------
module wlevd_table #(
   parameter int MAX_EVENTS = wlevd_pkg::MAX_EVENTS_DEF,
   localparam int SLOT_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [SLOT_W-1:0]               wr_idx,
   input  wire wlevd_pkg::slot_entry_type       wr_entry,
   input  wire logic                            clr_en,
   input  wire logic [SLOT_W-1:0]               clr_idx,
   input  wire logic                            rd_en,
   input  wire logic [SLOT_W-1:0]               rd_idx,
   output wlevd_pkg::slot_entry_type            rd_entry,
   output logic      [MAX_EVENTS-1:0]           valid,
   output logic                                 free_any,
   output logic      [SLOT_W-1:0]               free_idx
);

   wlevd_pkg::slot_entry_type mem [MAX_EVENTS];
   wlevd_pkg::slot_entry_type rd_entry_ff;
   logic [MAX_EVENTS-1:0]     valid_ff;
   logic [MAX_EVENTS-1:0]     valid_in;

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int s = MAX_EVENTS - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (clr_en) begin
         valid_in[clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_idx];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign valid    = valid_ff;

endmodule
`default_nettype wire

// ----- rtl/wlevd_lanes.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wlevd_lanes
// One threshold, required count and hit counter per event slot.
// ----------------------------------------------------------------------------
module wlevd_lanes #(
   parameter int MAX_EVENTS = wlevd_pkg::MAX_EVENTS_DEF,
   localparam int SLOT_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1
) (
   input  wire logic                            clock,
   input  wire wlevd_pkg::lane_ctl_type         ctl,
   input  wire logic [SLOT_W-1:0]               load_idx,
   input  wire wlevd_pkg::slot_entry_type       load_entry,
   input  wire logic [wlevd_pkg::LEVEL_W-1:0]   noise_margin,
   input  wire logic [wlevd_pkg::LEVEL_W-1:0]   reading,
   output logic      [MAX_EVENTS-1:0]           fire
);

   logic [wlevd_pkg::LEVEL_W-1:0] thr_ff  [MAX_EVENTS];
   logic [wlevd_pkg::COUNT_W-1:0] need_ff [MAX_EVENTS];
   logic [wlevd_pkg::COUNT_W-1:0] hits_ff [MAX_EVENTS];
   logic [wlevd_pkg::LEVEL_W-1:0] thr_in;

   // threshold floors at zero
   assign thr_in = (load_entry.level > noise_margin) ? load_entry.level - noise_margin : '0;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         thr_ff[load_idx]  <= thr_in;
         need_ff[load_idx] <= load_entry.count;
      end
      for (int s = 0; s < MAX_EVENTS; s++) begin
         priority if (ctl.clear) begin
            hits_ff[s] <= '0;
         end else if (ctl.count && reading >= thr_ff[s]) begin
            hits_ff[s] <= hits_ff[s] + wlevd_pkg::COUNT_W'(1);
         end else begin
            hits_ff[s] <= hits_ff[s];
         end
      end
   end

   always_comb begin
      for (int s = 0; s < MAX_EVENTS; s++) begin
         fire[s] = hits_ff[s] >= need_ff[s];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/windowed_light_event_detector_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_light_event_detector_unit
// Light reading window with an event table; fires events on each sample.
// ----------------------------------------------------------------------------
// One item is worked on at a time. For a sample, the event table is read one
// slot a cycle into per-slot compare lanes, then the reading ring is read one
// entry a cycle with every lane comparing in parallel. A create or an unknown
// command goes straight to the result; a destroy walks the table one slot a
// cycle until it finds the target or reaches the last slot. The result
// register lets the next item be accepted while a result waits. The
// configuration channel is always ready.
module windowed_light_event_detector_unit #(
   parameter int WINDOW_SIZE = wlevd_pkg::WINDOW_SIZE_DEF,
   parameter int MAX_EVENTS  = wlevd_pkg::MAX_EVENTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // intensity[21:0], req_level[43:22], req_count[59:44], target_id[75:60], zero
   input  wire logic [79:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // new_id[15:0], fired_mask[31:16], reading_count[37:32], zero
   output logic [39:0]      rsp_tdata,
   // status[1:0]
   output logic [1:0]       rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [21:0] csr_data
);

   localparam int SLOT_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
   localparam int PTR_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_SCAN, S_FIRE, S_TALLY, S_DEST, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [SLOT_W:0]                     slot_cnt_ff, slot_cnt_in;
   logic [CNT_W-1:0]                    ring_cnt_ff, ring_cnt_in;
   logic                                tab_pend_ff, tab_pend_in;
   logic [SLOT_W-1:0]                   tab_pend_idx_ff, tab_pend_idx_in;
   logic                                ring_pend_ff, ring_pend_in;
   logic [wlevd_pkg::ID_W-1:0]          target_ff, target_in;
   logic [wlevd_pkg::ID_W-1:0]          id_ctr_ff, id_ctr_in;
   logic [wlevd_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [wlevd_pkg::ID_W-1:0]          new_id_ff, new_id_in;
   logic [MAX_EVENTS-1:0]               mask_ff, mask_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [wlevd_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [wlevd_pkg::ID_W-1:0]          rsp_new_id_ff;
   logic [wlevd_pkg::MASK_W-1:0]        rsp_mask_ff;
   logic [wlevd_pkg::HELD_W-1:0]        rsp_count_ff;
   logic [wlevd_pkg::LEVEL_W-1:0]       nm_ff;
   logic                                rsp_load;

   logic [wlevd_pkg::CMD_W-1:0]         cmd;
   logic [wlevd_pkg::LEVEL_W-1:0]       intensity;
   logic [wlevd_pkg::LEVEL_W-1:0]       req_level;
   logic [wlevd_pkg::REQ_CNT_W-1:0]     req_count;
   logic [wlevd_pkg::ID_W-1:0]          target_id;
   logic                                req_fire;

   logic                                push;
   logic                                ring_rd;
   logic [wlevd_pkg::LEVEL_W-1:0]       ring_data;
   logic [CNT_W-1:0]                    held;

   logic                                tab_wr, tab_clr, tab_rd;
   wlevd_pkg::slot_entry_type           tab_wr_entry, tab_rd_entry;
   logic [MAX_EVENTS-1:0]               valid;
   logic                                free_any;
   logic [SLOT_W-1:0]                   free_idx;

   wlevd_pkg::lane_ctl_type             lane_ctl;
   logic [MAX_EVENTS-1:0]               fire;

   assign cmd       = req_tuser;
   assign intensity = req_tdata[21:0];
   assign req_level = req_tdata[43:22];
   assign req_count = req_tdata[59:44];
   assign target_id = req_tdata[75:60];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign tab_wr_entry.id    = id_ctr_ff + wlevd_pkg::ID_W'(1);
   assign tab_wr_entry.level = req_level;
   assign tab_wr_entry.count = (req_count > wlevd_pkg::REQ_CNT_W'(WINDOW_SIZE))
                               ? wlevd_pkg::COUNT_W'(WINDOW_SIZE)
                               : wlevd_pkg::COUNT_W'(req_count);

   wlevd_ring #(.WINDOW_SIZE(WINDOW_SIZE)) u_ring (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_value (intensity),
      .rd_en      (ring_rd),
      .rd_addr    (ring_cnt_ff[PTR_W-1:0]),
      .rd_data    (ring_data),
      .held       (held)
   );

   wlevd_table #(.MAX_EVENTS(MAX_EVENTS)) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tab_wr),
      .wr_idx   (free_idx),
      .wr_entry (tab_wr_entry),
      .clr_en   (tab_clr),
      .clr_idx  (tab_pend_idx_ff),
      .rd_en    (tab_rd),
      .rd_idx   (slot_cnt_ff[SLOT_W-1:0]),
      .rd_entry (tab_rd_entry),
      .valid    (valid),
      .free_any (free_any),
      .free_idx (free_idx)
   );

   wlevd_lanes #(.MAX_EVENTS(MAX_EVENTS)) u_lanes (
      .clock        (clock),
      .ctl          (lane_ctl),
      .load_idx     (tab_pend_idx_ff),
      .load_entry   (tab_rd_entry),
      .noise_margin (nm_ff),
      .reading      (ring_data),
      .fire         (fire)
   );

   always_comb begin
      state_in        = state_ff;
      slot_cnt_in     = slot_cnt_ff;
      ring_cnt_in     = ring_cnt_ff;
      tab_pend_in     = 1'b0;
      tab_pend_idx_in = slot_cnt_ff[SLOT_W-1:0];
      ring_pend_in    = 1'b0;
      target_in       = target_ff;
      id_ctr_in       = id_ctr_ff;
      status_in       = status_ff;
      new_id_in       = new_id_ff;
      mask_in         = mask_ff;
      push            = 1'b0;
      ring_rd         = 1'b0;
      tab_wr          = 1'b0;
      tab_clr         = 1'b0;
      tab_rd          = 1'b0;
      rsp_load        = 1'b0;
      lane_ctl        = '0;
      lane_ctl.load   = tab_pend_ff;
      lane_ctl.count  = ring_pend_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               target_in   = target_id;
               status_in   = wlevd_pkg::ST_OK;
               new_id_in   = '0;
               mask_in     = '0;
               slot_cnt_in = '0;
               ring_cnt_in = '0;
               unique case (cmd)
                  wlevd_pkg::CMD_SAMPLE: begin
                     push           = 1'b1;
                     lane_ctl.clear = 1'b1;
                     state_in       = S_LOAD;
                  end
                  wlevd_pkg::CMD_CREATE: begin
                     priority if (req_count == '0 || req_level > wlevd_pkg::MAX_LEVEL) begin
                        status_in = wlevd_pkg::ST_INVALID;
                     end else if (!free_any) begin
                        status_in = wlevd_pkg::ST_FULL;
                     end else begin
                        tab_wr    = 1'b1;
                        id_ctr_in = tab_wr_entry.id;
                        new_id_in = tab_wr_entry.id;
                     end
                     state_in = S_FINISH;
                  end
                  wlevd_pkg::CMD_DESTROY: begin
                     state_in = S_DEST;
                  end
                  default: begin
                     status_in = wlevd_pkg::ST_INVALID;
                     state_in  = S_FINISH;
                  end
               endcase
            end
         end
         S_LOAD: begin
            tab_rd      = 1'b1;
            tab_pend_in = 1'b1;
            slot_cnt_in = slot_cnt_ff + (SLOT_W + 1)'(1);
            if (slot_cnt_ff == (SLOT_W + 1)'(MAX_EVENTS - 1)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ring_rd      = 1'b1;
            ring_pend_in = 1'b1;
            ring_cnt_in  = ring_cnt_ff + CNT_W'(1);
            if (ring_cnt_in == held) begin
               state_in = S_FIRE;
            end
         end
         S_FIRE: begin
            state_in = S_TALLY;
         end
         S_TALLY: begin
            mask_in  = fire & valid;
            state_in = S_FINISH;
         end
         S_DEST: begin
            if (slot_cnt_ff < (SLOT_W + 1)'(MAX_EVENTS)) begin
               tab_rd      = 1'b1;
               tab_pend_in = 1'b1;
               slot_cnt_in = slot_cnt_ff + (SLOT_W + 1)'(1);
            end
            if (tab_pend_ff) begin
               priority if (valid[tab_pend_idx_ff] && tab_rd_entry.id == target_ff) begin
                  tab_clr   = 1'b1;
                  status_in = wlevd_pkg::ST_OK;
                  state_in  = S_FINISH;
               end else if (tab_pend_idx_ff == SLOT_W'(MAX_EVENTS - 1)) begin
                  status_in = wlevd_pkg::ST_NO_EVENT;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_DEST;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tab_pend_ff  <= 1'b0;
         ring_pend_ff <= 1'b0;
         id_ctr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         nm_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         tab_pend_ff  <= tab_pend_in;
         ring_pend_ff <= ring_pend_in;
         id_ctr_ff    <= id_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            nm_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_cnt_ff     <= slot_cnt_in;
      ring_cnt_ff     <= ring_cnt_in;
      tab_pend_idx_ff <= tab_pend_idx_in;
      target_ff       <= target_in;
      status_ff       <= status_in;
      new_id_ff       <= new_id_in;
      mask_ff         <= mask_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_new_id_ff <= new_id_ff;
         rsp_mask_ff   <= wlevd_pkg::MASK_W'(mask_ff);
         rsp_count_ff  <= wlevd_pkg::HELD_W'(held);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_mask_ff, rsp_new_id_ff};

`ifndef SYNTHESIS
   a_fire_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mask_ff != '0 |-> rsp_status_ff == wlevd_pkg::ST_OK
                                          && rsp_new_id_ff == '0)
      else $error("fired events on a result that is not a clean sample");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != wlevd_pkg::ST_OK
         |-> rsp_new_id_ff == '0 && rsp_mask_ff == '0)
      else $error("failed command carries an id or fired events");

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> ring_cnt_ff < held)
      else $error("ring scan beyond held readings");
`endif

endmodule
`default_nettype wire

// ----- dv/wlevd_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// wlevd_tb_pkg
// Expected-result tracking for the windowed light event detector bench.
// Keeps its own copy of the reading window, the event table and the
// identifier counter, works out the result of every accepted item and
// compares the results from the block against them in order.
// ----------------------------------------------------------------------------
package wlevd_tb_pkg;

   localparam int WIN   = wlevd_pkg::WINDOW_SIZE_DEF;
   localparam int SLOTS = wlevd_pkg::MAX_EVENTS_DEF;

   localparam logic [wlevd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [wlevd_pkg::STATUS_W-1:0] status;
      logic [wlevd_pkg::ID_W-1:0]     new_id;
      logic [wlevd_pkg::MASK_W-1:0]   fired;
      logic [wlevd_pkg::HELD_W-1:0]   held;
   } detector_result_type;

   class light_event_predictor_type;
      logic [wlevd_pkg::LEVEL_W-1:0] ring [WIN];
      int                            wr_ptr;
      bit                            ring_full;
      bit                            live [SLOTS];
      logic [wlevd_pkg::ID_W-1:0]    ev_id [SLOTS];
      logic [wlevd_pkg::LEVEL_W-1:0] ev_level [SLOTS];
      int                            ev_need [SLOTS];
      logic [wlevd_pkg::ID_W-1:0]    id_counter;
      logic [wlevd_pkg::LEVEL_W-1:0] margin;
      detector_result_type           awaited [$];
      int                            mismatches;
      int                            results_seen;
      int                            per_cmd [4];

      function new();
         wr_ptr       = 0;
         ring_full    = 1'b0;
         id_counter   = '0;
         margin       = '0;
         mismatches   = 0;
         results_seen = 0;
         foreach (ring[k]) ring[k] = '0;
         foreach (live[s]) live[s] = 1'b0;
         foreach (per_cmd[c]) per_cmd[c] = 0;
      endfunction

      function int held_count();
         return ring_full ? WIN : wr_ptr;
      endfunction

      // random identifier of a live event, -1 when the table is empty
      function int pick_live_id();
         int ids [$];
         foreach (live[s]) if (live[s]) ids.push_back(int'(ev_id[s]));
         if (ids.size() == 0) return -1;
         return ids[$urandom_range(0, ids.size() - 1)];
      endfunction

      function detector_result_type apply_item(logic [wlevd_pkg::CMD_W-1:0] cmd,
            logic [wlevd_pkg::LEVEL_W-1:0] reading, logic [wlevd_pkg::LEVEL_W-1:0] level,
            logic [wlevd_pkg::REQ_CNT_W-1:0] need, logic [wlevd_pkg::ID_W-1:0] target);
         detector_result_type           r;
         logic [wlevd_pkg::LEVEL_W-1:0] thr;
         int                            hits;
         int                            slot;
         r = '0;
         r.status = wlevd_pkg::ST_OK;
         case (cmd)
            wlevd_pkg::CMD_SAMPLE: begin
               ring[wr_ptr] = (reading > wlevd_pkg::MAX_LEVEL) ? wlevd_pkg::MAX_LEVEL
                                                              : reading;
               wr_ptr++;
               if (wr_ptr == WIN) begin
                  wr_ptr    = 0;
                  ring_full = 1'b1;
               end
               for (int s = 0; s < SLOTS; s++) begin
                  if (live[s]) begin
                     thr  = (ev_level[s] > margin) ? ev_level[s] - margin : '0;
                     hits = 0;
                     for (int k = 0; k < held_count(); k++)
                        if (ring[k] >= thr) hits++;
                     if (hits >= ev_need[s]) r.fired[s] = 1'b1;
                  end
               end
            end
            wlevd_pkg::CMD_CREATE: begin
               slot = -1;
               for (int s = SLOTS - 1; s >= 0; s--)
                  if (!live[s]) slot = s;
               if (need == 0 || level > wlevd_pkg::MAX_LEVEL) begin
                  r.status = wlevd_pkg::ST_INVALID;
               end else if (slot < 0) begin
                  r.status = wlevd_pkg::ST_FULL;
               end else begin
                  id_counter     = id_counter + wlevd_pkg::ID_W'(1);
                  live[slot]     = 1'b1;
                  ev_id[slot]    = id_counter;
                  ev_level[slot] = level;
                  ev_need[slot]  = (need > WIN) ? WIN : int'(need);
                  r.new_id       = id_counter;
               end
            end
            wlevd_pkg::CMD_DESTROY: begin
               // lowest slot wins when identifiers repeat
               slot = -1;
               for (int s = 0; s < SLOTS; s++)
                  if (slot < 0 && live[s] && ev_id[s] == target) slot = s;
               r.status = wlevd_pkg::ST_NO_EVENT;
               if (slot >= 0) begin
                  live[slot] = 1'b0;
                  r.status   = wlevd_pkg::ST_OK;
               end
            end
            default: begin
               r.status = wlevd_pkg::ST_INVALID;
            end
         endcase
         r.held = wlevd_pkg::HELD_W'(held_count());
         return r;
      endfunction

      function void note_item(logic [wlevd_pkg::CMD_W-1:0] cmd,
            logic [wlevd_pkg::LEVEL_W-1:0] reading, logic [wlevd_pkg::LEVEL_W-1:0] level,
            logic [wlevd_pkg::REQ_CNT_W-1:0] need, logic [wlevd_pkg::ID_W-1:0] target);
         per_cmd[cmd]++;
         awaited.push_back(apply_item(cmd, reading, level, need, target));
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         mismatches++;
         $display("mismatch: %s got 0x%0h want 0x%0h at result %0d",
                  what, got, want, results_seen);
      endtask

      task check_result(detector_result_type got);
         detector_result_type want;
         results_seen++;
         if (awaited.size() == 0) begin
            report("result with no item pending", got, 0);
         end else begin
            want = awaited.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.new_id !== want.new_id) report("new_id", got.new_id, want.new_id);
            if (got.fired !== want.fired) report("fired_mask", got.fired, want.fired);
            if (got.held !== want.held) report("reading_count", got.held, want.held);
         end
      endtask
   endclass

endpackage

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Bench for windowed_light_event_detector_unit.
// Directed items hit the field extremes, every command, argument checks,
// missing events and saturation; random phases under several noise margins
// mix samples, creates and destroys, with random stalls on both streams in
// all phases but one; a final steady run empties the table and refills it.
// ----------------------------------------------------------------------------
module tb_top;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [21:0] csr_data   = '0;

   wlevd_tb_pkg::light_event_predictor_type detector;
   bit  steady       = 1'b0;   // no idling on either side
   int  stall_left   = 0;
   int  quiet_cycles = 0;
   int  margins_used = 0;

   windowed_light_event_detector_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic send_item(input logic [wlevd_pkg::CMD_W-1:0] cmd,
         input logic [wlevd_pkg::LEVEL_W-1:0] reading,
         input logic [wlevd_pkg::LEVEL_W-1:0] level,
         input logic [wlevd_pkg::REQ_CNT_W-1:0] need,
         input logic [wlevd_pkg::ID_W-1:0] target);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'd0, target, need, level, reading};
      do @(posedge clock); while (!req_tready);
      detector.note_item(cmd, reading, level, need, target);
   endtask

   task automatic write_margin(input logic [wlevd_pkg::LEVEL_W-1:0] value);
      req_tvalid <= 1'b0;
      while (detector.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      detector.margin = value;
      margins_used++;
   endtask

   task automatic send_random(input int create_pct);
      int                              pick;
      int                              id;
      logic [wlevd_pkg::LEVEL_W-1:0]   reading;
      logic [wlevd_pkg::LEVEL_W-1:0]   level;
      logic [wlevd_pkg::REQ_CNT_W-1:0] need;
      logic [wlevd_pkg::ID_W-1:0]      target;
      reading = ($urandom_range(0, 99) < 85)
                ? wlevd_pkg::LEVEL_W'($urandom_range(0, wlevd_pkg::MAX_LEVEL))
                : wlevd_pkg::LEVEL_W'($urandom);
      level   = wlevd_pkg::LEVEL_W'($urandom);
      need    = wlevd_pkg::REQ_CNT_W'($urandom);
      target  = wlevd_pkg::ID_W'($urandom);
      pick    = $urandom_range(0, 99);
      if (pick < 50) begin
         send_item(wlevd_pkg::CMD_SAMPLE, reading, level, need, target);
      end else if (pick < 50 + create_pct) begin
         if ($urandom_range(0, 99) < 88) begin
            level = wlevd_pkg::LEVEL_W'($urandom_range(0, wlevd_pkg::MAX_LEVEL));
            need  = ($urandom_range(0, 99) < 80)
                    ? wlevd_pkg::REQ_CNT_W'($urandom_range(1, wlevd_tb_pkg::WIN))
                    : wlevd_pkg::REQ_CNT_W'($urandom_range(wlevd_tb_pkg::WIN + 1, 65535));
         end
         send_item(wlevd_pkg::CMD_CREATE, reading, level, need, target);
      end else if (pick < 95) begin
         id = detector.pick_live_id();
         if (id >= 0 && $urandom_range(0, 99) < 85) target = wlevd_pkg::ID_W'(id);
         send_item(wlevd_pkg::CMD_DESTROY, reading, level, need, target);
      end else begin
         send_item(wlevd_tb_pkg::CMD_UNUSED, reading, level, need, target);
      end
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         detector.check_result(wlevd_tb_pkg::detector_result_type'{rsp_tuser,
               rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[37:32]});
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 4000) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      logic [wlevd_pkg::ID_W-1:0] anchor;
      int                         id;
      detector = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_margin('0);

      send_item(wlevd_pkg::CMD_SAMPLE, '0, '0, '0, '0);
      send_item(wlevd_pkg::CMD_SAMPLE, '1, '1, '1, '1);
      send_item(wlevd_pkg::CMD_SAMPLE, wlevd_pkg::MAX_LEVEL, '0, '0, '0);
      send_item(wlevd_tb_pkg::CMD_UNUSED, '1, '1, '1, '1);
      send_item(wlevd_pkg::CMD_CREATE, '0, 22'd100, 16'd0, '0);
      send_item(wlevd_pkg::CMD_CREATE, '0, wlevd_pkg::MAX_LEVEL + 22'd1, 16'd5, '0);
      send_item(wlevd_pkg::CMD_CREATE, '0, wlevd_pkg::MAX_LEVEL, 16'hFFFF, '0);
      send_item(wlevd_pkg::CMD_CREATE, '0, '0, 16'd1, '0);
      send_item(wlevd_pkg::CMD_CREATE, '0, '1, 16'd1, '0);
      send_item(wlevd_pkg::CMD_DESTROY, '0, '0, '0, 16'hFFFF);
      send_item(wlevd_pkg::CMD_SAMPLE, 22'd1000, '0, '0, '0);
      send_item(wlevd_pkg::CMD_DESTROY, '0, '0, '0, 16'd2);
      send_item(wlevd_pkg::CMD_DESTROY, '0, '0, '0, 16'd2);
      send_item(wlevd_pkg::CMD_CREATE, '0, wlevd_pkg::MAX_LEVEL, 16'(wlevd_tb_pkg::WIN), '0);
      send_item(wlevd_pkg::CMD_CREATE, '0, 22'd1000, 16'(wlevd_tb_pkg::WIN + 1), '0);
      send_item(wlevd_pkg::CMD_SAMPLE, wlevd_pkg::MAX_LEVEL, '0, '0, '0);
      send_item(wlevd_pkg::CMD_SAMPLE, 22'd999, '0, '0, '0);
      send_item(wlevd_pkg::CMD_DESTROY, '0, '0, '0, 16'd1);
      send_item(wlevd_pkg::CMD_DESTROY, '0, '0, '0, 16'd3);
      send_item(wlevd_pkg::CMD_SAMPLE, '0, '0, '0, '0);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_margin(wlevd_pkg::MAX_LEVEL);
            1: write_margin(wlevd_pkg::LEVEL_W'($urandom_range(1, wlevd_pkg::MAX_LEVEL - 1)));
            2: write_margin(22'd1);
            3: write_margin(wlevd_pkg::LEVEL_W'($urandom_range(2 ** 21, wlevd_pkg::MAX_LEVEL)));
            default: write_margin('0);
         endcase
         steady = (ph == 2);
         for (int n = 0; n < 400; n++) send_random((ph == 3) ? 15 : 26);
      end

      // empty the table, then refill it and destroy the first new event, also once it is gone
      steady = 1'b1;
      id = detector.pick_live_id();
      while (id >= 0) begin
         send_item(wlevd_pkg::CMD_DESTROY, '0, '0, '0, wlevd_pkg::ID_W'(id));
         id = detector.pick_live_id();
      end
      send_item(wlevd_pkg::CMD_CREATE, '0, '0, 16'd1, '0);
      anchor = detector.id_counter;
      send_item(wlevd_pkg::CMD_CREATE, '0, wlevd_pkg::MAX_LEVEL, 16'd1, '0);
      send_item(wlevd_pkg::CMD_SAMPLE, wlevd_pkg::MAX_LEVEL, '0, '0, '0);
      send_item(wlevd_pkg::CMD_DESTROY, '0, '0, '0, anchor);
      send_item(wlevd_pkg::CMD_SAMPLE, '0, '0, '0, '0);
      send_item(wlevd_pkg::CMD_DESTROY, '0, '0, '0, anchor);
      send_item(wlevd_pkg::CMD_DESTROY, '0, '0, '0, anchor);

      req_tvalid <= 1'b0;
      steady = 1'b0;
      while (detector.awaited.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("run: %0d samples, %0d creates, %0d destroys, %0d unused codes, %0d results",
               detector.per_cmd[wlevd_pkg::CMD_SAMPLE], detector.per_cmd[wlevd_pkg::CMD_CREATE],
               detector.per_cmd[wlevd_pkg::CMD_DESTROY],
               detector.per_cmd[wlevd_tb_pkg::CMD_UNUSED], detector.results_seen);
      $display("run: %0d noise margin settings, table emptied and refilled up to id %0d",
               margins_used, detector.id_counter);
      if (detector.mismatches == 0 && detector.awaited.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/wlevd_pkg.sv
rtl/wlevd_ring.sv
rtl/wlevd_table.sv
rtl/wlevd_lanes.sv
rtl/windowed_light_event_detector_unit.sv
dv/wlevd_tb_pkg.sv
dv/tb_top.sv
